// ----- sv/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tiled pixel plotter package
// Sizes, constants, status codes and the map coordinate wrap shared by the
// plotter and its memories.
// ----------------------------------------------------------------------------
package tpp_pkg;

	localparam int MAP_SIDE   = 32;   // map cells per side, 8..32
	localparam int TILE_COUNT = 256;  // tiles in the pattern store, 16..256
	localparam int TILE_SIDE  = 8;    // rows per tile

	localparam int CELL_DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int CELL_W     = $clog2(CELL_DEPTH);
	localparam int ROW_DEPTH  = TILE_COUNT * TILE_SIDE;
	localparam int ROW_W      = $clog2(ROW_DEPTH);
	localparam int FILL_W     = $clog2(TILE_SIDE);

	localparam logic [7:0] FIRST_FREE_RESET = 8'd128;
	localparam logic [7:0] LEFT_PIXEL       = 8'h80;
	localparam logic [7:0] EMPTY_TILE       = 8'd0;
	localparam logic [8:0] ALLOC_LIMIT      = 9'(TILE_COUNT - 1);

	typedef enum logic [1:0] {
		ST_UPDATED   = 2'd0,
		ST_ALLOCATED = 2'd1,
		ST_DROPPED   = 2'd2
	} plot_status_t;

	// cell coordinate (coordinate / 8) wrapped into the map
	function automatic logic [4:0] map_wrap(input logic [4:0] v);
		logic [5:0] w;
		w = {1'b0, v};
		for (int i = 0; i < 4; i++) begin
			if (w >= 6'(MAP_SIDE)) begin
				w = w - 6'(MAP_SIDE);
			end
		end
		return w[4:0];
	endfunction

	function automatic logic [CELL_W-1:0] cell_index(input logic [7:0] col,
			input logic [7:0] row);
		logic [15:0] idx;
		idx = 16'(map_wrap(row[7:3])) * 16'(MAP_SIDE) + 16'(map_wrap(col[7:3]));
		return idx[CELL_W-1:0];
	endfunction

	function automatic logic [ROW_W-1:0] row_index(input logic [7:0] tile,
			input logic [FILL_W-1:0] line);
		logic [15:0] idx;
		idx = 16'(tile) * 16'(TILE_SIDE) + 16'(line);
		return idx[ROW_W-1:0];
	endfunction

endpackage

// ----- sv/tiled_pixel_plotter.sv -----
// ----------------------------------------------------------------------------
// Tiled pixel plotter
// Sets one pixel in a tiled framebuffer: map cell lookup, tile allocation on
// empty cells, and a read-modify-write of the addressed tile row.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pixel request: s_tdata = {pixel_row, pixel_col}.
//   m_* returns one result per request: m_tdata = {row_pattern, tile_used},
//   m_tuser = plot_status (updated, allocated, dropped).
//   cfg_we/cfg_wdata load first_free_tile and restart the tile allocator;
//   write it only while no request is in flight.
// Sequence: one request at a time. A pixel in an existing tile goes through
//   map read, row read, row write and result push; a drop through map read
//   and result push; a fresh tile has its 8 rows cleared one per cycle
//   through the single write port of the tile row memory.
// Reset: the map memory is swept to empty, one cell per cycle, over all
//   MAP_SIDE*MAP_SIDE (1024) cells with s_tready low; the allocator starts
//   at 128. Tile rows need no sweep: a tile is cleared when it is allocated.
// Stall: a result waits in the output register while the next request is
//   taken and worked on; the block holds its following result until
//   m_tready frees the output register.
// ----------------------------------------------------------------------------
module tiled_pixel_plotter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,   // first_free_tile
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [7:0] pixel_col, [15:8] pixel_row
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [7:0] tile_used, [15:8] row_pattern
	output logic [1:0]  m_tuser      // [1:0] plot_status
);

	import tpp_pkg::*;

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		MAP_RD,
		ROW_RD,
		FILL,
		PUSH
	} state_t;

	state_t             state_q;
	logic [CELL_W-1:0]  clr_q;
	logic [7:0]         alloc_q;
	logic [CELL_W-1:0]  cell_q;
	logic [FILL_W-1:0]  py_q;
	logic [7:0]         mask_q;
	logic [7:0]         tile_q;
	logic [ROW_W-1:0]   row_addr_q;
	logic [FILL_W-1:0]  fill_q;
	plot_status_t       res_status_q;
	logic [7:0]         res_tile_q;
	logic [7:0]         res_row_q;
	logic               m_tvalid_q;
	plot_status_t       m_status_q;
	logic [7:0]         m_tile_q;
	logic [7:0]         m_row_q;

	logic               accept;
	logic               out_free;
	logic               push;
	logic               cell_empty;
	logic               exhausted;
	logic               fill_last;

	logic               cell_we;
	logic [CELL_W-1:0]  cell_waddr;
	logic [7:0]         cell_wdata;
	logic [CELL_W-1:0]  cell_raddr;
	logic [7:0]         cell_rdata;

	logic               row_we;
	logic [ROW_W-1:0]   row_waddr;
	logic [7:0]         row_wdata;
	logic [ROW_W-1:0]   row_raddr;
	logic [7:0]         row_rdata;
	logic [7:0]         fill_data;

	assign s_tready   = (state_q == IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign push       = (state_q == PUSH) && out_free;
	assign cell_empty = (cell_rdata == EMPTY_TILE);
	assign exhausted  = ({1'b0, alloc_q} >= ALLOC_LIMIT);
	assign fill_last  = (fill_q == FILL_W'(TILE_SIDE - 1));
	assign fill_data  = (fill_q == py_q) ? mask_q : 8'd0;

	// map memory: sweep after reset, tile number on allocation
	assign cell_raddr = cell_index(s_tdata[7:0], s_tdata[15:8]);
	assign cell_we    = (state_q == CLEAR) ||
	                    (state_q == MAP_RD && cell_empty && !exhausted);
	assign cell_waddr = (state_q == CLEAR) ? clr_q : cell_q;
	assign cell_wdata = (state_q == CLEAR) ? EMPTY_TILE : alloc_q;

	// tile row memory: row writeback, or clear-and-set of a fresh tile
	assign row_raddr  = row_index(cell_rdata, py_q);
	assign row_we     = (state_q == ROW_RD) || (state_q == FILL);
	assign row_waddr  = (state_q == ROW_RD) ? row_addr_q : row_index(tile_q, fill_q);
	assign row_wdata  = (state_q == ROW_RD) ? (row_rdata | mask_q) : fill_data;

	tpp_ram #(
		.WIDTH (8),
		.DEPTH (CELL_DEPTH)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	tpp_ram #(
		.WIDTH (8),
		.DEPTH (ROW_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CLEAR;
			clr_q        <= '0;
			alloc_q      <= FIRST_FREE_RESET;
			cell_q       <= '0;
			py_q         <= '0;
			mask_q       <= 8'd0;
			tile_q       <= 8'd0;
			row_addr_q   <= '0;
			fill_q       <= '0;
			res_status_q <= ST_UPDATED;
			res_tile_q   <= 8'd0;
			res_row_q    <= 8'd0;
			m_tvalid_q   <= 1'b0;
			m_status_q   <= ST_UPDATED;
			m_tile_q     <= 8'd0;
			m_row_q      <= 8'd0;
		end else begin
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				alloc_q <= cfg_wdata;
			end
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_W'(CELL_DEPTH - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (accept) begin
						cell_q  <= cell_raddr;
						py_q    <= FILL_W'(s_tdata[10:8]);
						mask_q  <= LEFT_PIXEL >> s_tdata[2:0];
						state_q <= MAP_RD;
					end
				end
				MAP_RD: begin
					if (!cell_empty) begin
						tile_q     <= cell_rdata;
						row_addr_q <= row_raddr;
						state_q    <= ROW_RD;
					end else if (exhausted) begin
						res_status_q <= ST_DROPPED;
						res_tile_q   <= 8'd0;
						res_row_q    <= 8'd0;
						state_q      <= PUSH;
					end else begin
						tile_q  <= alloc_q;
						alloc_q <= alloc_q + 8'd1;
						fill_q  <= '0;
						state_q <= FILL;
					end
				end
				ROW_RD: begin
					res_status_q <= ST_UPDATED;
					res_tile_q   <= tile_q;
					res_row_q    <= row_rdata | mask_q;
					state_q      <= PUSH;
				end
				FILL: begin
					fill_q <= fill_q + FILL_W'(1);
					if (fill_last) begin
						res_status_q <= ST_ALLOCATED;
						res_tile_q   <= tile_q;
						res_row_q    <= mask_q;
						state_q      <= PUSH;
					end
				end
				PUSH: begin
					if (out_free) begin
						m_status_q <= res_status_q;
						m_tile_q   <= res_tile_q;
						m_row_q    <= res_row_q;
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_row_q, m_tile_q};
	assign m_tuser  = m_status_q;

endmodule

// ----- sv/tpp_ram.sv -----
// ----------------------------------------------------------------------------
// Tiled pixel plotter RAM
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module tpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
